// ===== rtl/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg : shared types and constants for the indexed list store
// Command codes, fixed field widths and the per-cycle broadcast to the cells.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int BLOCKS_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_SET    = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    // Broadcast from the controller to every cell; go_* only on a good transfer
    typedef struct packed {
        logic             go_add;
        logic             go_remove;
        logic             go_set;
        logic [POS_W-1:0] pos;
    } bcast_t;

    // Result fields other than the element itself
    typedef struct packed {
        logic                status;
        logic                use_read;
        logic [COUNT_W-1:0]  count;
        logic [BLOCKS_W-1:0] blocks;
    } result_t;

endpackage

// ===== rtl/indexed_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove : indexed list store with insert and remove
// Row of element cells with a shared controller and one output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries cmd, pos and value; a transfer
//   happens when in_valid is high and in_stall low. Output channel
//   (out_valid/out_stall) carries data, status, count and blocks_used, one
//   result per command, in order.
//   Every command completes in the cycle of its transfer: all cells shift or
//   load together, so its result sits in the output register in the next
//   cycle. One command per cycle is taken while the receiver keeps up.
//   in_stall rises only while a result waits and out_stall is high; the
//   result then holds until taken, and a new command is taken in the same
//   cycle that the waiting result leaves.
//   Reset empties the list (count 0, one block in use) and drops any waiting
//   result. Element contents are not cleared; only positions below count are
//   ever read.
//   Errors (bad position, full list, unknown command) give status 1 and
//   data 0 and leave the list unchanged.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ilir_pkg::CMD_W-1:0]        cmd,
    input  logic [ilir_pkg::POS_W-1:0]        pos,
    input  logic [ilir_pkg::VALUE_W-1:0]      value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ilir_pkg::DATA_W-1:0]       data,
    output logic                              status,
    output logic [ilir_pkg::COUNT_W-1:0]      count,
    output logic [ilir_pkg::BLOCKS_W-1:0]     blocks_used
);
    import ilir_pkg::*;

    logic                  accept;
    bcast_t                bc;
    result_t               res;
    logic [ELEM_WIDTH-1:0] wr_value;
    logic [ELEM_WIDTH-1:0] q   [CAPACITY];
    logic [ELEM_WIDTH-1:0] rd  [CAPACITY];
    logic [ELEM_WIDTH-1:0] lo  [CAPACITY];
    logic [ELEM_WIDTH-1:0] up  [CAPACITY];
    logic [ELEM_WIDTH-1:0] rd_all;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_W-1:0]     data_reg;
    logic [DATA_W-1:0]     data_next;
    logic                  status_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [BLOCKS_W-1:0]   blocks_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign wr_value = ELEM_WIDTH'(value);

    ilir_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (accept),
        .cmd   (cmd),
        .pos   (pos),
        .bc    (bc),
        .res   (res)
    );

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign lo[gi] = '0;
            end
            else
            begin : g_lo
                assign lo[gi] = q[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign up[gi] = '0;
            end
            else
            begin : g_up
                assign up[gi] = q[gi+1];
            end

            ilir_cell #(
                .CAPACITY   (CAPACITY),
                .ELEM_WIDTH (ELEM_WIDTH),
                .IDX        (gi)
            ) u_cell (
                .clk      (clk),
                .bc       (bc),
                .wr_value (wr_value),
                .lower    (lo[gi]),
                .upper    (up[gi]),
                .q        (q[gi]),
                .rd       (rd[gi])
            );
        end
    endgenerate

    // at most one cell matches pos, so an OR of the read taps selects it
    always_comb
    begin
        rd_all = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_all = rd_all | rd[i];
        end
    end

    assign data_next = res.use_read ? DATA_W'(rd_all) : '0;

    always_comb
    begin
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_next;
            status_reg <= res.status;
            count_reg  <= res.count;
            blocks_reg <= res.blocks;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data        = data_reg;
    assign status      = status_reg;
    assign count       = count_reg;
    assign blocks_used = blocks_reg;

endmodule

// ===== rtl/ilir_cell.sv =====
// ----------------------------------------------------------------------------
// ilir_cell : one element slot of the list
// Holds one element and takes its neighbour's value when the list shifts.
// ----------------------------------------------------------------------------
module ilir_cell #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  ilir_pkg::bcast_t      bc,
    input  logic [ELEM_WIDTH-1:0] wr_value,
    input  logic [ELEM_WIDTH-1:0] lower,
    input  logic [ELEM_WIDTH-1:0] upper,
    output logic [ELEM_WIDTH-1:0] q,
    output logic [ELEM_WIDTH-1:0] rd
);
    import ilir_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [ELEM_WIDTH-1:0] elem_reg;
    logic [ELEM_WIDTH-1:0] elem_next;
    logic [IW-1:0]         pos_i;
    logic                  hit;
    logic                  above;

    // pos is below CAPACITY whenever any go_* is set
    assign pos_i = IW'(bc.pos);
    assign hit   = (MY_IDX == pos_i);
    assign above = (MY_IDX > pos_i);

    always_comb
    begin
        priority if (bc.go_add && above)
        begin
            elem_next = lower;
        end
        else if ((bc.go_add || bc.go_set) && hit)
        begin
            elem_next = wr_value;
        end
        else if (bc.go_remove && (hit || above))
        begin
            elem_next = upper;
        end
        else
        begin
            elem_next = elem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    assign q  = elem_reg;
    assign rd = hit ? elem_reg : '0;

endmodule

// ===== rtl/ilir_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilir_ctrl : length and block count keeping for the indexed list store
// Checks each command, drives the cell broadcast and works out the status.
// ----------------------------------------------------------------------------
module ilir_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic [ilir_pkg::CMD_W-1:0]          cmd,
    input  logic [ilir_pkg::POS_W-1:0]          pos,
    output ilir_pkg::bcast_t                    bc,
    output ilir_pkg::result_t                   res
);
    import ilir_pkg::*;

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int BLK_W  = LEN_W + 1;
    localparam int PROD_W = 2 * BLK_W + 1;
    localparam int CMP_W  = (POS_W > LEN_W) ? POS_W : LEN_W;

    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;
    logic [BLK_W-1:0]  blocks_reg;
    logic [BLK_W-1:0]  blocks_next;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  len_c;
    logic [PROD_W-1:0] tri_cur;
    logic [PROD_W-1:0] tri_low;
    logic [BLK_W-1:0]  b_low;
    logic [LEN_W-1:0]  len_dec;
    logic              full;
    logic              err;
    logic              ok_add;
    logic              ok_remove;
    logic              ok_set;
    logic              ok_get;

    assign pos_c   = CMP_W'(pos);
    assign len_c   = CMP_W'(length_reg);
    assign full    = (length_reg == LEN_W'(CAPACITY));
    assign len_dec = length_reg - LEN_W'(1);
    assign b_low   = blocks_reg - BLK_W'(2);

    // triangular sizes b(b+1)/2 and (b-2)(b-1)/2
    assign tri_cur = PROD_W'((PROD_W'(blocks_reg) * (PROD_W'(blocks_reg) + PROD_W'(1))) >> 1);
    assign tri_low = PROD_W'((PROD_W'(b_low) * (PROD_W'(b_low) + PROD_W'(1))) >> 1);

    always_comb
    begin
        err = 1'b0;
        unique case (cmd_t'(cmd))
            CMD_ADD:    err = (pos_c > len_c) || full;
            CMD_REMOVE: err = (pos_c >= len_c);
            CMD_GET:    err = (pos_c >= len_c);
            CMD_SET:    err = (pos_c >= len_c);
            CMD_CLEAR:  err = 1'b0;
            default:    err = 1'b1;
        endcase
    end

    assign ok_add    = go && !err && (cmd == CMD_ADD);
    assign ok_remove = go && !err && (cmd == CMD_REMOVE);
    assign ok_set    = go && !err && (cmd == CMD_SET);
    assign ok_get    = go && !err && (cmd == CMD_GET);

    // tri(b-2) < length <= tri(b) holds between commands, so a single remove
    // drops at most one block and a clear always leaves one
    always_comb
    begin
        length_next = length_reg;
        blocks_next = blocks_reg;
        priority if (ok_add)
        begin
            length_next = length_reg + LEN_W'(1);
            if (tri_cur <= PROD_W'(length_reg))
            begin
                blocks_next = blocks_reg + BLK_W'(1);
            end
        end
        else if (ok_remove)
        begin
            length_next = len_dec;
            if ((blocks_reg > BLK_W'(1)) && (tri_low >= PROD_W'(len_dec)))
            begin
                blocks_next = blocks_reg - BLK_W'(1);
            end
        end
        else if (go && (cmd == CMD_CLEAR))
        begin
            length_next = '0;
            blocks_next = BLK_W'(1);
        end
        else
        begin
            length_next = length_reg;
            blocks_next = blocks_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            blocks_reg <= BLK_W'(1);
        end
        else
        begin
            length_reg <= length_next;
            blocks_reg <= blocks_next;
        end
    end

    always_comb
    begin
        bc.go_add    = ok_add;
        bc.go_remove = ok_remove;
        bc.go_set    = ok_set;
        bc.pos       = pos;
    end

    always_comb
    begin
        res.status   = err;
        res.use_read = ok_remove || ok_get || ok_set;
        res.count    = COUNT_W'(length_next);
        res.blocks   = BLOCKS_W'(blocks_next);
    end

endmodule

// ===== tb/sv/list_result_checker.sv =====
// ----------------------------------------------------------------------------
// list_result_checker : result checker for the indexed list store
// Watches both channels, keeps its own copy of the list, length and block
// count, works out the result of every command taken and compares each
// result leaving the block with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module list_result_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [ilir_pkg::CMD_W-1:0]    cmd,
    input  logic [ilir_pkg::POS_W-1:0]    pos,
    input  logic [ilir_pkg::VALUE_W-1:0]  value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [ilir_pkg::DATA_W-1:0]   data,
    input  logic                          status,
    input  logic [ilir_pkg::COUNT_W-1:0]  count,
    input  logic [ilir_pkg::BLOCKS_W-1:0] blocks_used,
    output int                            fail_count,
    output int                            outstanding
);

    import ilir_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    typedef struct {
        logic [DATA_W-1:0]   data;
        logic                status;
        logic [COUNT_W-1:0]  count;
        logic [BLOCKS_W-1:0] blocks;
    } list_result_t;

    logic [VALUE_W-1:0] list_cells [CAPACITY];
    int                 list_len;
    int                 block_cnt;
    list_result_t       expected_q [$];
    list_result_t       oldest;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
        foreach (list_cells[i]) list_cells[i] = '0;
    end

    // elements held by b triangular blocks
    function automatic int blocks_hold(input int b);
        return b * (b + 1) / 2;
    endfunction

    function automatic void release_blocks();
        while (block_cnt > 1 && blocks_hold(block_cnt - 2) >= list_len)
            block_cnt--;
    endfunction

    function automatic list_result_t apply_command(input logic [CMD_W-1:0] c,
                                                   input logic [POS_W-1:0] p,
                                                   input logic [VALUE_W-1:0] v);
        list_result_t     r;
        int               i;
        logic [IDX_W-1:0] at;
        r.data   = '0;
        r.status = 1'b0;
        // only used where p is a valid position
        at       = IDX_W'(p);
        case (c)
            CMD_ADD:
                if (int'(p) > list_len || list_len >= CAPACITY) r.status = 1'b1;
                else
                begin
                    if (blocks_hold(block_cnt) < list_len + 1) block_cnt++;
                    for (i = list_len; i > int'(p); i--)
                        list_cells[IDX_W'(i)] = list_cells[IDX_W'(i-1)];
                    list_cells[at] = v;
                    list_len++;
                end
            CMD_REMOVE:
                if (int'(p) >= list_len) r.status = 1'b1;
                else
                begin
                    r.data = list_cells[at];
                    for (i = int'(p); i + 1 < list_len; i++)
                        list_cells[IDX_W'(i)] = list_cells[IDX_W'(i+1)];
                    list_len--;
                    release_blocks();
                end
            CMD_GET:
                if (int'(p) >= list_len) r.status = 1'b1;
                else r.data = list_cells[at];
            CMD_SET:
                if (int'(p) >= list_len) r.status = 1'b1;
                else
                begin
                    r.data         = list_cells[at];
                    list_cells[at] = v;
                end
            CMD_CLEAR:
            begin
                list_len = 0;
                release_blocks();
            end
            default:
                r.status = 1'b1;
        endcase
        r.count  = list_len[COUNT_W-1:0];
        r.blocks = block_cnt[BLOCKS_W-1:0];
        return r;
    endfunction

    function automatic void note_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s: expected 0x%08h, got 0x%08h", field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_len  = 0;
            block_cnt = 1;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result transfer with nothing outstanding: data 0x%08h", data);
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    if (data !== oldest.data) note_mismatch("data", oldest.data, data);
                    if (status !== oldest.status) note_mismatch("status", oldest.status, status);
                    if (count !== oldest.count) note_mismatch("count", oldest.count, count);
                    if (blocks_used !== oldest.blocks)
                        note_mismatch("blocks_used", oldest.blocks, blocks_used);
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(apply_command(cmd, pos, value));
            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_indexed_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove : testbench for the indexed list store
// Directed commands on the edge cases, then random bursts that fill, drain
// and churn the list under three idling regimes; results are checked by
// list_result_checker and a stall watchdog bounds the run.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_remove;

    import ilir_pkg::*;

    localparam int               LIST_CAPACITY      = 64;
    localparam int               PHASE_ITEMS        = 520;
    localparam int               QUIET_LIMIT        = 4000;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_FIRST  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LAST   = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd;
    logic [POS_W-1:0]    pos;
    logic [VALUE_W-1:0]  value;
    logic                out_valid;
    logic                out_stall;
    logic [DATA_W-1:0]   data;
    logic                status;
    logic [COUNT_W-1:0]  count;
    logic [BLOCKS_W-1:0] blocks_used;

    int fail_count;
    int outstanding;
    int send_idle_pct;
    int recv_stall_pct;
    int len_est;
    int quiet_cycles;

    indexed_list_insert_remove #(
        .CAPACITY   (LIST_CAPACITY),
        .ELEM_WIDTH (32)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pos         (pos),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data        (data),
        .status      (status),
        .count       (count),
        .blocks_used (blocks_used)
    );

    list_result_checker #(
        .CAPACITY (LIST_CAPACITY)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pos         (pos),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data        (data),
        .status      (status),
        .count       (count),
        .blocks_used (blocks_used),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);

    // Watchdog: cycles in a row with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("indexed_list_insert_remove verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_command(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                                input logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        pos      <= p;
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // rough length tracking, only used to aim positions
        case (c)
            CMD_ADD:    if (int'(p) <= len_est && len_est < LIST_CAPACITY) len_est++;
            CMD_REMOVE: if (int'(p) < len_est) len_est--;
            CMD_CLEAR:  len_est = 0;
            default:    ;
        endcase
    endtask

    // hold the input side off until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(input logic [CMD_W-1:0] c);
        if ($urandom_range(0, 99) >= 88) return POS_W'($urandom_range(0, 127));
        if (c == CMD_ADD) return POS_W'($urandom_range(0, len_est));
        if (len_est > 0) return POS_W'($urandom_range(0, len_est - 1));
        return '0;
    endfunction

    task automatic random_command(input int add_pct, input int remove_pct);
        int               roll;
        logic [CMD_W-1:0] c;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) c = CMD_ADD;
        else if (roll < add_pct + remove_pct) c = CMD_REMOVE;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 47) c = CMD_GET;
            else if (roll < 95) c = CMD_SET;
            else if (roll < 97) c = CMD_CLEAR;
            else c = CMD_W'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
        end
        send_command(c, pick_pos(c), pick_value());
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int sent;
        int burst;
        int add_pct;
        int remove_pct;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent           = 0;
        // fill to capacity at random positions, then push against the full store
        while (len_est < LIST_CAPACITY)
        begin
            send_command(CMD_ADD, POS_W'($urandom_range(0, len_est)), pick_value());
            sent++;
        end
        repeat (3)
        begin
            send_command(CMD_ADD, POS_W'($urandom_range(0, LIST_CAPACITY)), pick_value());
            sent++;
        end
        while (sent < PHASE_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    add_pct    = 85;
                    remove_pct = 5;
                end
                1:
                begin
                    add_pct    = 10;
                    remove_pct = 75;
                end
                default:
                begin
                    add_pct    = 35;
                    remove_pct = 35;
                end
            endcase
            burst = $urandom_range(20, 90);
            repeat (burst) random_command(add_pct, remove_pct);
            sent += burst;
        end
        drain_results();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_GET;
        pos            = '0;
        value          = '0;
        out_stall      = 1'b0;
        send_idle_pct  = 26;
        recv_stall_pct = 69;
        len_est        = 0;
        quiet_cycles   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list errors, inserts at both ends and the middle, reads, removes, unknown commands and clears
        send_command(CMD_GET,    7'd0,   32'h0000_0001);
        send_command(CMD_REMOVE, 7'd0,   32'h0000_0002);
        send_command(CMD_SET,    7'd0,   32'h0000_0003);
        send_command(CMD_ADD,    7'd1,   32'h0000_0004);
        send_command(CMD_ADD,    7'd0,   32'hFFFF_FFFF);
        send_command(CMD_ADD,    7'd0,   32'h0000_0000);
        send_command(CMD_ADD,    7'd2,   32'hA5A5_A5A5);
        send_command(CMD_ADD,    7'd1,   32'h5A5A_5A5A);
        send_command(CMD_ADD,    7'd127, 32'h1111_1111);
        send_command(CMD_GET,    7'd0,   32'h0);
        send_command(CMD_GET,    7'd3,   32'h0);
        send_command(CMD_GET,    7'd4,   32'h0);
        send_command(CMD_SET,    7'd2,   32'h1234_5678);
        send_command(CMD_REMOVE, 7'd1,   32'h0);
        send_command(CMD_REMOVE, 7'd2,   32'h0);
        send_command(CMD_REMOVE, 7'd127, 32'h0);
        send_command(CMD_UNKNOWN_FIRST,      7'd127, 32'hFFFF_FFFF);
        send_command(CMD_UNKNOWN_FIRST + 1'b1, 7'd0, 32'h0);
        send_command(CMD_UNKNOWN_LAST,       7'd1,   32'hFFFF_FFFF);
        send_command(CMD_CLEAR,  7'd0,   32'h0);
        send_command(CMD_CLEAR,  7'd127, 32'hFFFF_FFFF);
        send_command(CMD_ADD,    7'd0,   32'hDEAD_BEEF);
        send_command(CMD_REMOVE, 7'd0,   32'h0);
        drain_results();

        run_phase(26, 69);
        run_phase(69, 26);
        run_phase(0, 0);

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("indexed_list_insert_remove verification clean");
        else
            $display("indexed_list_insert_remove verification failed");
        $finish;
    end

endmodule
